/* hw/rtl/pfw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the priority-flood trapped-water block.
// No dependencies; used by every module under hw/rtl.
package pfw_pkg;

    // Default sizing
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_HEIGHT_BITS = 16;

    // Fixed port widths
    localparam int HEIGHT_IN_W = 16;
    localparam int WATER_W     = 28;
    localparam int CFG_DIM_W   = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [WATER_W-1:0]   WATER_MAX    = {WATER_W{1'b1}};
    localparam logic [CFG_DIM_W-1:0] DIM_RESET    = 7'd64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    // Neighbor directions: east, south, west, north
    typedef enum logic [1:0] {
        DIR_EAST,
        DIR_SOUTH,
        DIR_WEST,
        DIR_NORTH
    } pfw_dir_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SEED_SCAN,
        ST_SEED_PUSH,
        ST_SEED_WAIT,
        ST_POP,
        ST_POP_WAIT,
        ST_BASE,
        ST_NB_SEL,
        ST_NB_CHK,
        ST_PUSH_WAIT,
        ST_EMIT
    } pfw_state_t;

    // Heap sequencer states
    typedef enum logic [2:0] {
        H_IDLE,
        H_UP_RD,
        H_UP_CMP,
        H_DN_LD,
        H_DN_RD,
        H_DN_CMP
    } pfw_heap_state_t;

    // Heap command and status
    typedef struct packed {
        logic push;
        logic pop;
    } pfw_heap_cmd_t;

    typedef struct packed {
        logic busy;
        logic empty;
    } pfw_heap_sts_t;

endpackage

/* hw/rtl/pfw_grid_mem.sv */
`timescale 1ns / 1ps
// Height store and visited map: two single-port-write memories sharing one
// read address, read data registered. Depends on pfw_pkg for its default sizing.
module pfw_grid_mem #(
    parameter int DEPTH = pfw_pkg::DEF_MAX_ROWS * pfw_pkg::DEF_MAX_COLS,
    parameter int HB    = pfw_pkg::DEF_HEIGHT_BITS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          h_we,
    input  logic [AW-1:0] h_waddr,
    input  logic [HB-1:0] h_wdata,
    input  logic          v_we,
    input  logic [AW-1:0] v_waddr,
    input  logic          v_wdata,
    input  logic [AW-1:0] raddr,
    output logic [HB-1:0] h_rdata,
    output logic          v_rdata
);
    import pfw_pkg::*;

    logic [HB-1:0] height_mem [DEPTH];
    logic          visit_mem  [DEPTH];

    // Height store
    always_ff @(posedge aclk) begin
        if (h_we) begin
            height_mem[h_waddr] <= h_wdata;
        end
        h_rdata <= height_mem[raddr];
    end

    // Visited map
    always_ff @(posedge aclk) begin
        if (v_we) begin
            visit_mem[v_waddr] <= v_wdata;
        end
        v_rdata <= visit_mem[raddr];
    end

endmodule

/* hw/rtl/pfw_heap.sv */
`timescale 1ns / 1ps
// Min-heap in a synchronous memory (one write, two read ports) with a
// sift-up / sift-down sequencer. Depends on pfw_pkg.
module pfw_heap #(
    parameter int DEPTH = pfw_pkg::DEF_MAX_ROWS * pfw_pkg::DEF_MAX_COLS,
    parameter int KEY_W = pfw_pkg::DEF_HEIGHT_BITS,
    parameter int TAG_W = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pfw_pkg::pfw_heap_cmd_t cmd,
    input  logic [KEY_W-1:0]       push_key,
    input  logic [TAG_W-1:0]       push_tag,
    output pfw_pkg::pfw_heap_sts_t sts,
    output logic [KEY_W-1:0]       pop_key,
    output logic [TAG_W-1:0]       pop_tag
);
    import pfw_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam int XW = AW + 2;
    localparam int EW = KEY_W + TAG_W;

    logic [EW-1:0] heap_mem [DEPTH];

    pfw_heap_state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [EW-1:0]   item_reg, item_next;
    logic [EW-1:0]   top_reg, top_next;
    logic [EW-1:0]   rd_a_q, rd_b_q;

    logic            we;
    logic [AW-1:0]   waddr, ra, rb;
    logic [EW-1:0]   wdata;

    logic [AW-1:0]   par_idx;
    logic [XW-1:0]   lch, rch;
    logic            l_ok, r_ok, go_up, go_l, go_r;
    logic [KEY_W-1:0] item_key;

    // Index arithmetic and compares
    always_comb begin
        item_key = item_reg[EW-1 -: KEY_W];
        par_idx  = AW'((k_reg - 1'b1) >> 1);
        lch      = {1'b0, k_reg, 1'b1};
        rch      = lch + 1'b1;
        l_ok     = lch < XW'(cnt_reg);
        r_ok     = rch < XW'(cnt_reg);
        go_up    = rd_a_q[EW-1 -: KEY_W] > item_key;
        go_l     = l_ok && (rd_a_q[EW-1 -: KEY_W] < item_key);
        go_r     = r_ok && (rd_b_q[EW-1 -: KEY_W] < item_key) &&
                   !(go_l && (rd_a_q[EW-1 -: KEY_W] <= rd_b_q[EW-1 -: KEY_W]));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            H_IDLE: begin
                if (cmd.push && (cnt_reg < CW'(DEPTH))) begin
                    state_next = H_UP_RD;
                end else if (cmd.pop && (cnt_reg != '0)) begin
                    state_next = H_DN_LD;
                end
            end
            H_UP_RD:  state_next = (k_reg == '0) ? H_IDLE : H_UP_CMP;
            H_UP_CMP: state_next = go_up ? H_UP_RD : H_IDLE;
            H_DN_LD:  state_next = (cnt_reg == '0) ? H_IDLE : H_DN_RD;
            H_DN_RD:  state_next = H_DN_CMP;
            H_DN_CMP: state_next = (go_l || go_r) ? H_DN_RD : H_IDLE;
            default:  state_next = H_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        cnt_next  = cnt_reg;
        k_next    = k_reg;
        item_next = item_reg;
        top_next  = top_reg;
        we        = 1'b0;
        waddr     = k_reg;
        wdata     = item_reg;
        ra        = '0;
        rb        = '0;
        unique case (state_reg)
            H_IDLE: begin
                if (cmd.push && (cnt_reg < CW'(DEPTH))) begin
                    item_next = {push_key, push_tag};
                    k_next    = AW'(cnt_reg);
                    cnt_next  = cnt_reg + 1'b1;
                end else if (cmd.pop && (cnt_reg != '0)) begin
                    ra       = '0;
                    rb       = AW'(cnt_reg - 1'b1);
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            H_UP_RD: begin
                ra = par_idx;
                if (k_reg == '0) begin
                    we = 1'b1;
                end
            end
            H_UP_CMP: begin
                we = 1'b1;
                if (go_up) begin
                    wdata  = rd_a_q;
                    k_next = par_idx;
                end
            end
            H_DN_LD: begin
                top_next  = rd_a_q;
                item_next = rd_b_q;
                k_next    = '0;
            end
            H_DN_RD: begin
                ra = lch[AW-1:0];
                rb = rch[AW-1:0];
            end
            H_DN_CMP: begin
                we = 1'b1;
                if (go_r) begin
                    wdata  = rd_b_q;
                    k_next = rch[AW-1:0];
                end else if (go_l) begin
                    wdata  = rd_a_q;
                    k_next = lch[AW-1:0];
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Heap memory
    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        rd_a_q <= heap_mem[ra];
        rd_b_q <= heap_mem[rb];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        item_reg <= item_next;
        top_reg  <= top_next;
    end

    assign sts.busy  = (state_reg != H_IDLE);
    assign sts.empty = (cnt_reg == '0);
    assign pop_key   = top_reg[EW-1 -: KEY_W];
    assign pop_tag   = top_reg[TAG_W-1:0];

endmodule

/* hw/rtl/priority_flood_trapped_water_top.sv */
`timescale 1ns / 1ps
// Top level of the priority-flood trapped-water engine: flood controller,
// grid memories (pfw_grid_mem) and min-heap (pfw_heap). Depends on pfw_pkg.
//
//  Channel | Ports                                   | Transaction
//  --------+-----------------------------------------+------------------------------
//  input   | s_valid s_ready s_cell_height s_last_cell | one height cell, row-major
//  result  | m_valid m_ready m_trapped_water         | total water of one grid
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | write rows (0) or cols (1)
//
// Loading accepts one cell per cycle. The last cell starts a flood: a visited-map
// clearing pass over all MAX_ROWS*MAX_COLS cells, a border scan of the rows*cols
// cells that marks each border cell and inserts it in the heap, then per popped
// cell the pop and up to four neighbor checks, each unvisited neighbor being
// marked and inserted in the heap.
// The heap memory's read latency sets the pace of each sift step.
// Reset is synchronous, active low. s_ready is low during a flood and while a
// finished total waits on a stalled result channel.
module priority_flood_trapped_water_top #(
    parameter int MAX_ROWS    = pfw_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = pfw_pkg::DEF_MAX_COLS,
    parameter int HEIGHT_BITS = pfw_pkg::DEF_HEIGHT_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pfw_pkg::HEIGHT_IN_W-1:0] s_cell_height,
    input  logic                            s_last_cell,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pfw_pkg::WATER_W-1:0]     m_trapped_water,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfw_pkg::CFG_DIM_W-1:0]   cfg_data
);
    import pfw_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DRW   = $clog2(MAX_ROWS + 1);
    localparam int DCW   = $clog2(MAX_COLS + 1);
    localparam int HB    = HEIGHT_BITS;
    localparam int SW    = ((HB > WATER_W) ? HB : WATER_W) + 1;
    localparam int TAG_W = RW + CLW;

    // Clamp a dimension register to 1..max
    function automatic logic [DRW-1:0] clamp_rows(input logic [CFG_DIM_W-1:0] v);
        logic [DRW-1:0] res;
        if (v == '0) res = DRW'(1);
        else if (int'(v) > MAX_ROWS) res = DRW'(MAX_ROWS);
        else res = DRW'(v);
        return res;
    endfunction

    function automatic logic [DCW-1:0] clamp_cols(input logic [CFG_DIM_W-1:0] v);
        logic [DCW-1:0] res;
        if (v == '0) res = DCW'(1);
        else if (int'(v) > MAX_COLS) res = DCW'(MAX_COLS);
        else res = DCW'(v);
        return res;
    endfunction

    pfw_state_t             state_reg, state_next;
    logic [CFG_DIM_W-1:0]   rows_reg, cols_reg;
    logic [DRW-1:0]         nr_reg, nr_next;
    logic [DCW-1:0]         nc_reg, nc_next;
    logic [AW:0]            load_idx_reg, load_idx_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [RW-1:0]          r_reg, r_next;
    logic [CLW-1:0]         c_reg, c_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [HB-1:0]          lvl_reg, lvl_next;
    logic [AW-1:0]          base_reg, base_next;
    pfw_dir_t               dir_reg, dir_next;
    logic [AW-1:0]          nb_addr_reg, nb_addr_next;
    logic [RW-1:0]          nb_r_reg, nb_r_next;
    logic [CLW-1:0]         nb_c_reg, nb_c_next;
    logic [WATER_W-1:0]     water_reg, water_next;
    logic [WATER_W-1:0]     out_reg, out_next;
    logic                   m_valid_reg, m_valid_next;

    // Grid memory ports
    logic                   g_h_we, g_v_we, g_v_wdata, g_v_rdata;
    logic [AW-1:0]          g_h_waddr, g_v_waddr, g_raddr;
    logic [HB-1:0]          g_h_wdata, g_h_rdata;

    // Heap ports
    pfw_heap_cmd_t          hcmd;
    pfw_heap_sts_t          hsts;
    logic [HB-1:0]          push_key, pop_key;
    logic [TAG_W-1:0]       push_tag, pop_tag;

    logic [HB+HEIGHT_IN_W-1:0] h_ext;
    logic [HB-1:0]          h_in;
    logic                   s_fire, emit_fire;
    logic                   border, scan_last, last_dir;
    logic                   nb_ok;
    logic [AW:0]            base_x, nc_x;
    logic [AW-1:0]          nb_addr;
    logic [RW-1:0]          nb_r;
    logic [CLW-1:0]         nb_c;
    logic [SW-1:0]          diff, sum;
    logic [HB-1:0]          push_lvl;

    assign h_ext     = {{HB{1'b0}}, s_cell_height};
    assign h_in      = h_ext[HB-1:0];
    assign s_ready   = (state_reg == ST_LOAD);
    assign s_fire    = s_valid && s_ready;
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    // Border test and end of scan
    assign border    = (r_reg == '0) || (DRW'(r_reg) == nr_reg - 1'b1) ||
                       (c_reg == '0) || (DCW'(c_reg) == nc_reg - 1'b1);
    assign scan_last = (DRW'(r_reg) == nr_reg - 1'b1) && (DCW'(c_reg) == nc_reg - 1'b1);
    assign last_dir  = (dir_reg == DIR_NORTH);

    // Neighbor selection for the current direction
    assign base_x = {1'b0, base_reg};
    assign nc_x   = (AW+1)'(nc_reg);
    always_comb begin
        nb_ok   = 1'b0;
        nb_addr = base_reg;
        nb_r    = r_reg;
        nb_c    = c_reg;
        unique case (dir_reg)
            DIR_EAST: begin
                nb_ok   = (DCW'(c_reg) + 1'b1) < nc_reg;
                nb_addr = AW'(base_x + 1'b1);
                nb_r    = r_reg;
                nb_c    = c_reg + 1'b1;
            end
            DIR_SOUTH: begin
                nb_ok   = (DRW'(r_reg) + 1'b1) < nr_reg;
                nb_addr = AW'(base_x + nc_x);
                nb_r    = r_reg + 1'b1;
                nb_c    = c_reg;
            end
            DIR_WEST: begin
                nb_ok   = (c_reg != '0);
                nb_addr = AW'(base_x - 1'b1);
                nb_r    = r_reg;
                nb_c    = c_reg - 1'b1;
            end
            DIR_NORTH: begin
                nb_ok   = (r_reg != '0);
                nb_addr = AW'(base_x - nc_x);
                nb_r    = r_reg - 1'b1;
                nb_c    = c_reg;
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // Water accumulation with saturation
    always_comb begin
        diff     = (lvl_reg > g_h_rdata) ? (SW'(lvl_reg) - SW'(g_h_rdata)) : '0;
        sum      = SW'(water_reg) + diff;
        push_lvl = (lvl_reg > g_h_rdata) ? lvl_reg : g_h_rdata;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (s_fire && s_last_cell) state_next = ST_CLEAR;
            ST_CLEAR:     if (clr_reg == AW'(CELLS - 1)) state_next = ST_SEED_SCAN;
            ST_SEED_SCAN: begin
                if (border) state_next = ST_SEED_PUSH;
                else if (scan_last) state_next = ST_POP;
            end
            ST_SEED_PUSH: state_next = ST_SEED_WAIT;
            ST_SEED_WAIT: begin
                if (!hsts.busy) state_next = scan_last ? ST_POP : ST_SEED_SCAN;
            end
            ST_POP:       state_next = hsts.empty ? ST_EMIT : ST_POP_WAIT;
            ST_POP_WAIT:  if (!hsts.busy) state_next = ST_BASE;
            ST_BASE:      state_next = ST_NB_SEL;
            ST_NB_SEL: begin
                if (nb_ok) state_next = ST_NB_CHK;
                else if (last_dir) state_next = ST_POP;
            end
            ST_NB_CHK: begin
                if (!g_v_rdata) state_next = ST_PUSH_WAIT;
                else state_next = last_dir ? ST_POP : ST_NB_SEL;
            end
            ST_PUSH_WAIT: begin
                if (!hsts.busy) state_next = last_dir ? ST_POP : ST_NB_SEL;
            end
            ST_EMIT:      if (emit_fire) state_next = ST_LOAD;
            default:      state_next = ST_LOAD;
        endcase
    end

    // Datapath, memory and heap control
    always_comb begin
        nr_next       = nr_reg;
        nc_next       = nc_reg;
        load_idx_next = load_idx_reg;
        clr_next      = clr_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        idx_next      = idx_reg;
        lvl_next      = lvl_reg;
        base_next     = base_reg;
        dir_next      = dir_reg;
        nb_addr_next  = nb_addr_reg;
        nb_r_next     = nb_r_reg;
        nb_c_next     = nb_c_reg;
        water_next    = water_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        g_h_we        = 1'b0;
        g_h_waddr     = load_idx_reg[AW-1:0];
        g_h_wdata     = h_in;
        g_v_we        = 1'b0;
        g_v_waddr     = idx_reg;
        g_v_wdata     = 1'b1;
        g_raddr       = idx_reg;
        hcmd          = '0;
        push_key      = g_h_rdata;
        push_tag      = {r_reg, c_reg};

        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (load_idx_reg < (AW+1)'(CELLS)) begin
                        g_h_we        = 1'b1;
                        load_idx_next = load_idx_reg + 1'b1;
                    end
                    if (s_last_cell) begin
                        nr_next  = clamp_rows(rows_reg);
                        nc_next  = clamp_cols(cols_reg);
                        clr_next = '0;
                    end
                end
            end
            ST_CLEAR: begin
                g_v_we    = 1'b1;
                g_v_waddr = clr_reg;
                g_v_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                r_next    = '0;
                c_next    = '0;
                idx_next  = '0;
                water_next = '0;
            end
            ST_SEED_SCAN, ST_SEED_WAIT: begin
                if ((state_reg == ST_SEED_SCAN && !border) ||
                    (state_reg == ST_SEED_WAIT && !hsts.busy)) begin
                    idx_next = idx_reg + 1'b1;
                    if (DCW'(c_reg) == nc_reg - 1'b1) begin
                        c_next = '0;
                        r_next = r_reg + 1'b1;
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            ST_SEED_PUSH: begin
                hcmd.push = 1'b1;
                g_v_we    = 1'b1;
            end
            ST_POP: begin
                hcmd.pop = !hsts.empty;
            end
            ST_POP_WAIT: begin
                lvl_next = pop_key;
                r_next   = pop_tag[TAG_W-1 -: RW];
                c_next   = pop_tag[CLW-1:0];
            end
            ST_BASE: begin
                base_next = AW'((AW+1)'(r_reg) * nc_x + (AW+1)'(c_reg));
                dir_next  = DIR_EAST;
            end
            ST_NB_SEL: begin
                g_raddr = nb_addr;
                if (nb_ok) begin
                    nb_addr_next = nb_addr;
                    nb_r_next    = nb_r;
                    nb_c_next    = nb_c;
                end else begin
                    dir_next = pfw_dir_t'(dir_reg + 2'd1);
                end
            end
            ST_NB_CHK: begin
                if (!g_v_rdata) begin
                    water_next = (sum > SW'(WATER_MAX)) ? WATER_MAX : sum[WATER_W-1:0];
                    g_v_we     = 1'b1;
                    g_v_waddr  = nb_addr_reg;
                    hcmd.push  = 1'b1;
                    push_key   = push_lvl;
                    push_tag   = {nb_r_reg, nb_c_reg};
                end else begin
                    dir_next = pfw_dir_t'(dir_reg + 2'd1);
                end
            end
            ST_PUSH_WAIT: begin
                if (!hsts.busy) dir_next = pfw_dir_t'(dir_reg + 2'd1);
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    out_next      = water_reg;
                    m_valid_next  = 1'b1;
                    load_idx_next = '0;
                end
            end
            default: begin
                hcmd = '0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_ROWS) rows_reg <= cfg_data;
            if (cfg_index == REG_COLS) cols_reg <= cfg_data;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_idx_reg <= load_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        nr_reg      <= nr_next;
        nc_reg      <= nc_next;
        clr_reg     <= clr_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        idx_reg     <= idx_next;
        lvl_reg     <= lvl_next;
        base_reg    <= base_next;
        dir_reg     <= dir_next;
        nb_addr_reg <= nb_addr_next;
        nb_r_reg    <= nb_r_next;
        nb_c_reg    <= nb_c_next;
        water_reg   <= water_next;
        out_reg     <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_trapped_water = out_reg;

    pfw_grid_mem #(
        .DEPTH (CELLS),
        .HB    (HB),
        .AW    (AW)
    ) u_grid (
        .aclk    (aclk),
        .h_we    (g_h_we),
        .h_waddr (g_h_waddr),
        .h_wdata (g_h_wdata),
        .v_we    (g_v_we),
        .v_waddr (g_v_waddr),
        .v_wdata (g_v_wdata),
        .raddr   (g_raddr),
        .h_rdata (g_h_rdata),
        .v_rdata (g_v_rdata)
    );

    pfw_heap #(
        .DEPTH (CELLS),
        .KEY_W (HB),
        .TAG_W (TAG_W)
    ) u_heap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (hcmd),
        .push_key (push_key),
        .push_tag (push_tag),
        .sts      (hsts),
        .pop_key  (pop_key),
        .pop_tag  (pop_tag)
    );

endmodule

/* hw/rtl/pfw_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the trapped-water top level, bound to it below.
// Depends on pfw_pkg and priority_flood_trapped_water_top.
module pfw_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [pfw_pkg::HEIGHT_IN_W-1:0] s_cell_height,
    input logic                            s_last_cell,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [pfw_pkg::WATER_W-1:0]     m_trapped_water,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [pfw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [pfw_pkg::CFG_DIM_W-1:0]   cfg_data
);
    import pfw_pkg::*;

    // A stalled result holds its total
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_trapped_water)))
        else $error("result changed while stalled");

    // The last cell starts a flood, so input stops being taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_cell) |=> !s_ready)
        else $error("input taken right after the last cell");

    // A result only appears at the end of a flood
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a flood");

    // Reset leaves the block ready for cells and with no result
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("bad state after reset");

endmodule

bind priority_flood_trapped_water_top pfw_checker u_pfw_checker (.*);
